/* hw/rtl/alflp_pkg.sv */
// Shared opcodes, sequencer states and constants for the linked list free pool.
package alflp_pkg;

	typedef enum logic [2:0] {
		OP_INSERT  = 3'd0,
		OP_REMOVE  = 3'd1,
		OP_READ    = 3'd2,
		OP_COMPARE = 3'd3,
		OP_FIND    = 3'd4
	} op_t;

	typedef enum logic [11:0] {
		S_CLR   = 12'b0000_0000_0001,
		S_IDLE  = 12'b0000_0000_0010,
		S_INS_A = 12'b0000_0000_0100,
		S_INS_B = 12'b0000_0000_1000,
		S_INS_C = 12'b0000_0001_0000,
		S_REM_H = 12'b0000_0010_0000,
		S_REM_P = 12'b0000_0100_0000,
		S_REM_Q = 12'b0000_1000_0000,
		S_REM_R = 12'b0001_0000_0000,
		S_RD    = 12'b0010_0000_0000,
		S_CMP   = 12'b0100_0000_0000,
		S_FL    = 12'b1000_0000_0000
	} state_t;

	localparam logic [6:0] IDX_NONE7 = 7'h7F;

endpackage

/* hw/rtl/alflp_link_mem.sv */
// Link memory: one write port, one registered read port.
module alflp_link_mem #(
	parameter int AW = 6,
	parameter int LW = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [LW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [LW-1:0] rdata
);

	logic [LW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/alflp_pay_mem.sv */
// Payload memory: one write port, two registered read ports.
module alflp_pay_mem #(
	parameter int AW = 6,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re_a,
	input  logic [AW-1:0] raddr_a,
	output logic [DW-1:0] rdata_a,
	input  logic          re_b,
	input  logic [AW-1:0] raddr_b,
	output logic [DW-1:0] rdata_b
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* hw/rtl/array_linked_list_free_pool.sv */
// Top level: list sequencer over link and payload memories.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------------
//  command  | start, busy              | opcode, position, other_position, payload_in
//  result   | done (one-cycle strobe)  | ok, payload_out, index_out, equal,
//           |                          | head_out, empty_res, full_res
//
// Read, compare, remove, insert and find last are sequenced over the link and payload
// memories; each link hop is one read of the single link memory port.
// Commands rejected at acceptance finish in the acceptance cycle; the result strobe is
// registered and follows in the cycle after the last step.
// After reset a clearing pass writes the initial free chain, with busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
module array_linked_list_free_pool import alflp_pkg::*; #(
	parameter int NODES     = 64,
	parameter int PAYLOAD_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        opcode,
	input  logic signed [6:0] position,
	input  logic [5:0]        other_position,
	input  logic [31:0]       payload_in,
	output logic              done,
	output logic              ok,
	output logic [31:0]       payload_out,
	output logic signed [6:0] index_out,
	output logic              equal,
	output logic signed [6:0] head_out,
	output logic              empty_res,
	output logic              full_res
);

	localparam int AW = $clog2(NODES);
	localparam int LW = AW + 1;
	localparam int CW = $clog2(NODES + 1);

	// link value: MSB set means none
	typedef logic [LW-1:0] link_t;
	localparam link_t LINK_NONE = {1'b1, {AW{1'b0}}};

	function automatic logic [AW-1:0] to_addr(input logic [5:0] p);
		logic [AW+5:0] t;
		t = {{AW{1'b0}}, p};
		return t[AW-1:0];
	endfunction

	function automatic logic [6:0] enc7(input link_t l);
		logic [AW+6:0] t;
		t = {7'd0, l[AW-1:0]};
		return l[AW] ? IDX_NONE7 : t[6:0];
	endfunction

	function automatic logic node_ok(input logic [5:0] p);
		return {26'd0, p} < 32'(NODES);
	endfunction

	function automatic logic [PAYLOAD_W-1:0] pay_ext(input logic [31:0] p);
		logic [PAYLOAD_W+31:0] t;
		t = {{PAYLOAD_W{1'b0}}, p};
		return t[PAYLOAD_W-1:0];
	endfunction

	function automatic logic [31:0] pay_trunc(input logic [PAYLOAD_W-1:0] p);
		logic [PAYLOAD_W+31:0] t;
		t = {32'd0, p};
		return t[31:0];
	endfunction

	state_t              state_q, state_d;
	link_t               head_q, head_d, free_q, free_d;
	logic [AW-1:0]       y_q, y_d, pos_q, pos_d;
	logic                pnone_q, pnone_d;
	logic [CW-1:0]       cnt_q, cnt_d, steps;

	logic                lk_we, lk_re;
	logic [AW-1:0]       lk_waddr, lk_raddr;
	link_t               lk_wdata, lk_rd;
	logic                py_we, py_rea, py_reb;
	logic [AW-1:0]       py_waddr, py_raddra, py_raddrb;
	logic [PAYLOAD_W-1:0] py_wdata, py_rda, py_rdb;

	logic                fin, f_ok, f_eq;
	logic [PAYLOAD_W-1:0] f_pout;
	link_t               f_idx;

	logic                done_q, ok_q, eq_q, empty_q, full_q;
	logic [31:0]         pout_q;
	logic [6:0]          idx_q, hres_q;

	logic                pnone, pvalid, ovalid;
	logic [AW-1:0]       paddr, clr_addr;
	link_t               clr_val;

	assign pnone    = position == IDX_NONE7;
	assign pvalid   = !position[6] && node_ok(position[5:0]);
	assign ovalid   = node_ok(other_position);
	assign paddr    = to_addr(position[5:0]);
	assign clr_addr = cnt_q[AW-1:0];
	assign clr_val  = (cnt_q == CW'(NODES - 1)) ? LINK_NONE
		: {1'b0, clr_addr + AW'(1)};
	assign steps    = cnt_q + CW'(1);

	alflp_link_mem #(.AW(AW), .LW(LW)) u_link (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.re    (lk_re),
		.raddr (lk_raddr),
		.rdata (lk_rd)
	);

	alflp_pay_mem #(.AW(AW), .DW(PAYLOAD_W)) u_pay (
		.clk     (clk),
		.we      (py_we),
		.waddr   (py_waddr),
		.wdata   (py_wdata),
		.re_a    (py_rea),
		.raddr_a (py_raddra),
		.rdata_a (py_rda),
		.re_b    (py_reb),
		.raddr_b (py_raddrb),
		.rdata_b (py_rdb)
	);

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		free_d    = free_q;
		y_d       = y_q;
		pos_d     = pos_q;
		pnone_d   = pnone_q;
		cnt_d     = cnt_q;
		lk_we     = 1'b0;
		lk_waddr  = y_q;
		lk_wdata  = free_q;
		lk_re     = 1'b0;
		lk_raddr  = paddr;
		py_we     = 1'b0;
		py_waddr  = free_q[AW-1:0];
		py_wdata  = pay_ext(payload_in);
		py_rea    = 1'b0;
		py_raddra = paddr;
		py_reb    = 1'b0;
		py_raddrb = to_addr(other_position);
		fin       = 1'b0;
		f_ok      = 1'b0;
		f_eq      = 1'b0;
		f_pout    = '0;
		f_idx     = LINK_NONE;
		unique case (state_q)
			S_CLR: begin
				lk_we    = 1'b1;
				lk_waddr = clr_addr;
				lk_wdata = clr_val;
				if (cnt_q == CW'(NODES - 1)) begin
					cnt_d   = '0;
					state_d = S_IDLE;
				end else begin
					cnt_d = steps;
				end
			end
			S_IDLE: begin
				if (start) begin
					pos_d   = paddr;
					pnone_d = pnone;
					case (op_t'(opcode))
						OP_INSERT: begin
							if (!free_q[AW] && (pnone || pvalid)) begin
								py_we    = 1'b1;
								lk_re    = 1'b1;
								lk_raddr = free_q[AW-1:0];
								y_d      = free_q[AW-1:0];
								state_d  = S_INS_A;
							end else begin
								fin = 1'b1;
							end
						end
						OP_REMOVE: begin
							if (head_q[AW]) begin
								fin = 1'b1;
							end else if (pnone) begin
								lk_re     = 1'b1;
								lk_raddr  = head_q[AW-1:0];
								py_rea    = 1'b1;
								py_raddra = head_q[AW-1:0];
								y_d       = head_q[AW-1:0];
								state_d   = S_REM_H;
							end else if (pvalid) begin
								lk_re   = 1'b1;
								state_d = S_REM_P;
							end else begin
								fin = 1'b1;
							end
						end
						OP_READ: begin
							if (pvalid) begin
								lk_re   = 1'b1;
								py_rea  = 1'b1;
								state_d = S_RD;
							end else begin
								fin = 1'b1;
							end
						end
						OP_COMPARE: begin
							if (pvalid && ovalid) begin
								py_rea  = 1'b1;
								py_reb  = 1'b1;
								state_d = S_CMP;
							end else begin
								fin = 1'b1;
							end
						end
						OP_FIND: begin
							if (head_q[AW]) begin
								fin = 1'b1;
							end else begin
								lk_re    = 1'b1;
								lk_raddr = head_q[AW-1:0];
								y_d      = head_q[AW-1:0];
								cnt_d    = '0;
								state_d  = S_FL;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_INS_A: begin
				free_d = lk_rd;
				if (pnone_q) begin
					lk_we    = 1'b1;
					lk_wdata = head_q;
					head_d   = {1'b0, y_q};
					fin      = 1'b1;
					f_ok     = 1'b1;
					f_idx    = {1'b0, y_q};
					state_d  = S_IDLE;
				end else begin
					lk_re    = 1'b1;
					lk_raddr = pos_q;
					state_d  = S_INS_B;
				end
			end
			S_INS_B: begin
				lk_we    = 1'b1;
				lk_wdata = lk_rd;
				state_d  = S_INS_C;
			end
			S_INS_C: begin
				lk_we    = 1'b1;
				lk_waddr = pos_q;
				lk_wdata = {1'b0, y_q};
				fin      = 1'b1;
				f_ok     = 1'b1;
				f_idx    = {1'b0, y_q};
				state_d  = S_IDLE;
			end
			S_REM_H: begin
				head_d  = lk_rd;
				lk_we   = 1'b1;
				free_d  = {1'b0, y_q};
				fin     = 1'b1;
				f_ok    = 1'b1;
				f_pout  = py_rda;
				state_d = S_IDLE;
			end
			S_REM_P: begin
				if (lk_rd[AW]) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					y_d       = lk_rd[AW-1:0];
					lk_re     = 1'b1;
					lk_raddr  = lk_rd[AW-1:0];
					py_rea    = 1'b1;
					py_raddra = lk_rd[AW-1:0];
					state_d   = S_REM_Q;
				end
			end
			S_REM_Q: begin
				lk_we    = 1'b1;
				lk_waddr = pos_q;
				lk_wdata = lk_rd;
				state_d  = S_REM_R;
			end
			S_REM_R: begin
				lk_we   = 1'b1;
				free_d  = {1'b0, y_q};
				fin     = 1'b1;
				f_ok    = 1'b1;
				f_pout  = py_rda;
				state_d = S_IDLE;
			end
			S_RD: begin
				fin     = 1'b1;
				f_pout  = py_rda;
				f_idx   = lk_rd;
				state_d = S_IDLE;
			end
			S_CMP: begin
				fin     = 1'b1;
				f_eq    = py_rda == py_rdb;
				state_d = S_IDLE;
			end
			S_FL: begin
				if (lk_rd[AW] || steps == CW'(NODES)) begin
					fin     = 1'b1;
					f_idx   = {1'b0, y_q};
					state_d = S_IDLE;
				end else begin
					lk_re    = 1'b1;
					lk_raddr = lk_rd[AW-1:0];
					y_d      = lk_rd[AW-1:0];
					cnt_d    = steps;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			head_q  <= LINK_NONE;
			free_q  <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			free_q  <= free_d;
			cnt_q   <= cnt_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		y_q     <= y_d;
		pos_q   <= pos_d;
		pnone_q <= pnone_d;
		if (fin) begin
			ok_q    <= f_ok;
			pout_q  <= pay_trunc(f_pout);
			idx_q   <= enc7(f_idx);
			eq_q    <= f_eq;
			hres_q  <= enc7(head_d);
			empty_q <= head_d[AW];
			full_q  <= free_d[AW];
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign ok          = ok_q;
	assign payload_out = pout_q;
	assign index_out   = idx_q;
	assign equal       = eq_q;
	assign head_out    = hres_q;
	assign empty_res   = empty_q;
	assign full_res    = full_q;

endmodule

/* hw/rtl/alflp_checker.sv */
// Port-level checker for the linked list free pool, bound to the top level.
module alflp_checker import alflp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic              ok,
	input logic signed [6:0] index_out,
	input logic              equal,
	input logic signed [6:0] head_out,
	input logic              empty_res
);

	// a result only follows an accepted command or ongoing work
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result without a command");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (empty_res == (head_out == IDX_NONE7)))
		else $error("empty flag disagrees with head");

	a_ok_eq: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(ok && equal))
		else $error("ok and equal both set");

	// a successful insert leaves the list non-empty
	a_ins_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ok && index_out != IDX_NONE7) |-> !empty_res)
		else $error("insert left list empty");

endmodule

bind array_linked_list_free_pool alflp_checker u_alflp_checker (.*);
